>>> hw/rtl/assert_macros.svh
// Assertion helpers included by vec3_normalize.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion clocked on the rising edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, also active during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/vn_pkg.sv
package vn_pkg;

    // Pipeline control that travels into every stage block.
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

>>> hw/rtl/vn_sqrt.sv
module vn_sqrt #(
    parameter int CW = 16,
    parameter int SW = 51
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vn_pkg::t_pipe_ctl  i_ctl,
    input  logic [2*CW-1:0]    i_sum,
    input  logic [SW-1:0]      i_side,
    output logic               o_valid,
    output logic [CW-1:0]      o_len,
    output logic [SW-1:0]      o_side
);
    import vn_pkg::*;

    localparam int SQW = 2 * CW;

    logic [SQW-1:0] r_rem  [CW];
    logic [SQW-1:0] r_root [CW];
    logic [SW-1:0]  r_side [CW];
    logic           r_vld  [CW];

    // One root bit is resolved per stage, most significant first.
    for (genvar g = 0; g < CW; g++) begin : g_stage
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (CW - 1 - g));
        logic [SQW-1:0] w_rem;
        logic [SQW-1:0] w_root;
        logic [SW-1:0]  w_side;
        logic           w_vld;
        logic [SQW-1:0] n_rem;
        logic [SQW-1:0] n_root;

        if (g == 0) begin : g_first
            assign w_rem  = i_sum;
            assign w_root = '0;
            assign w_side = i_side;
            assign w_vld  = i_ctl.valid;
        end else begin : g_next
            assign w_rem  = r_rem[g-1];
            assign w_root = r_root[g-1];
            assign w_side = r_side[g-1];
            assign w_vld  = r_vld[g-1];
        end

        always_comb begin
            if (w_rem >= w_root + BIT) begin
                n_rem  = w_rem - (w_root + BIT);
                n_root = (w_root >> 1) + BIT;
            end else begin
                n_rem  = w_rem;
                n_root = w_root >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[g] <= w_vld;
            end
            if (i_ctl.en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_side[g] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[CW-1];
    assign o_len   = r_root[CW-1][CW-1:0];
    assign o_side  = r_side[CW-1];

endmodule

>>> hw/rtl/vn_div.sv
module vn_div #(
    parameter int CW = 16,
    parameter int FRAC_OUT = 14,
    parameter int SW = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vn_pkg::t_pipe_ctl   i_ctl,
    input  logic [CW-1:0]       i_num,
    input  logic [CW-1:0]       i_den,
    input  logic [SW-1:0]       i_side,
    output logic                o_valid,
    output logic [FRAC_OUT:0]   o_quot,
    output logic [SW-1:0]       o_side
);
    import vn_pkg::*;

    localparam int NW = CW + FRAC_OUT;
    localparam int QW = FRAC_OUT + 1;
    localparam int DW = CW + QW;

    logic [NW-1:0] r_rem  [QW];
    logic [QW-1:0] r_quot [QW];
    logic [CW-1:0] r_den  [QW];
    logic [SW-1:0] r_side [QW];
    logic          r_vld  [QW];

    // Restoring division, one quotient bit per stage from the top down.
    for (genvar g = 0; g < QW; g++) begin : g_stage
        localparam int SH = QW - 1 - g;
        logic [NW-1:0] w_rem;
        logic [QW-1:0] w_quot;
        logic [CW-1:0] w_den;
        logic [SW-1:0] w_side;
        logic          w_vld;
        logic [DW-1:0] w_trial;
        logic [NW-1:0] n_rem;
        logic [QW-1:0] n_quot;

        if (g == 0) begin : g_first
            assign w_rem  = {i_num, FRAC_OUT'(0)};
            assign w_quot = '0;
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_vld  = i_ctl.valid;
        end else begin : g_next
            assign w_rem  = r_rem[g-1];
            assign w_quot = r_quot[g-1];
            assign w_den  = r_den[g-1];
            assign w_side = r_side[g-1];
            assign w_vld  = r_vld[g-1];
        end

        assign w_trial = DW'(w_den) << SH;

        always_comb begin
            n_quot = w_quot;
            if (DW'(w_rem) >= w_trial) begin
                n_rem      = w_rem - NW'(w_trial);
                n_quot[SH] = 1'b1;
            end else begin
                n_rem = w_rem;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[g] <= w_vld;
            end
            if (i_ctl.en) begin
                r_rem[g]  <= n_rem;
                r_quot[g] <= n_quot;
                r_den[g]  <= w_den;
                r_side[g] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quot  = r_quot[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

>>> hw/rtl/vec3_normalize.sv
// Vector normalizer: one signed 3D vector in, its unit vector and magnitude out.
// Input channel: i_valid with i_comp_x/y/z, held off by o_stall. A transaction
// completes on a rising edge with i_valid high and o_stall low.
// Output channel: o_valid with o_unit_x/y/z, o_length and o_degenerate, held
// off by i_stall. The result is the zero vector with o_degenerate set when the
// magnitude does not exceed the min_magnitude register (i_cfg_we/i_cfg_data).
// Stages in order: absolute value, squaring, summing, the square root pipeline,
// the threshold compare, the three divider lanes side by side, and the output
// register. One vector per cycle is accepted while o_stall is low; every stage
// is registered.
// When the receiver stalls while a result is shown, the whole pipeline holds and
// o_stall is raised; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits and the register to 0;
// configuration should only be written while the pipeline is empty.
module vec3_normalize #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_OUT = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [COMP_WIDTH-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COMP_WIDTH-1:0] i_comp_x,
    input  logic signed [COMP_WIDTH-1:0] i_comp_y,
    input  logic signed [COMP_WIDTH-1:0] i_comp_z,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [FRAC_OUT+1:0]   o_unit_x,
    output logic signed [FRAC_OUT+1:0]   o_unit_y,
    output logic signed [FRAC_OUT+1:0]   o_unit_z,
    output logic [COMP_WIDTH-1:0]        o_length,
    output logic                         o_degenerate
);
    import vn_pkg::*;

    localparam int CW = COMP_WIDTH;
    localparam int UW = FRAC_OUT + 2;
    localparam int SQ_SIDE = 3 * CW + 3;

    logic          en;
    t_pipe_ctl     ctl_in;
    logic [CW-1:0] r_min_mag;

    // Stage 1: absolute values.
    logic          r_vld1;
    logic [CW-1:0] r_abs1 [3];
    logic [2:0]    r_neg1;
    // Stage 2: squares.
    logic            r_vld2;
    logic [2*CW-1:0] r_sq2 [3];
    logic [CW-1:0]   r_abs2 [3];
    logic [2:0]      r_neg2;
    // Stage 3: sum of squares.
    logic            r_vld3;
    logic [2*CW-1:0] r_sum3;
    logic [CW-1:0]   r_abs3 [3];
    logic [2:0]      r_neg3;
    // Square root output.
    logic               sq_vld;
    logic [CW-1:0]      sq_len;
    logic [SQ_SIDE-1:0] sq_side;
    // Stage after the compare.
    logic          r_vld4;
    logic [CW-1:0] r_len4;
    logic [CW-1:0] r_abs4 [3];
    logic [2:0]    r_neg4;
    logic          r_deg4;
    // Divider outputs.
    logic              dv_vld;
    logic [FRAC_OUT:0] dv_quot [3];
    logic [1:0]        dv_side0;
    logic              dv_side1;
    logic              dv_side2;
    logic [CW-1:0]     dv_len;
    // Output register.
    logic          r_out_vld;
    logic [UW-1:0] r_unit [3];
    logic [CW-1:0] r_len_out;
    logic          r_deg_out;
    logic [UW-1:0] n_unit [3];

    // The pipeline advances unless a shown result is being held.
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;
    assign ctl_in  = '{en: en, valid: r_vld3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mag <= '0;
        end else if (i_cfg_we) begin
            r_min_mag <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
            r_vld4 <= sq_vld;
            r_out_vld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_neg1    <= {i_comp_z[CW-1], i_comp_y[CW-1], i_comp_x[CW-1]};
            r_abs1[0] <= i_comp_x[CW-1] ? CW'(-i_comp_x) : i_comp_x;
            r_abs1[1] <= i_comp_y[CW-1] ? CW'(-i_comp_y) : i_comp_y;
            r_abs1[2] <= i_comp_z[CW-1] ? CW'(-i_comp_z) : i_comp_z;
            for (int k = 0; k < 3; k++) begin
                r_sq2[k]  <= (2*CW)'(r_abs1[k]) * (2*CW)'(r_abs1[k]);
                r_abs2[k] <= r_abs1[k];
                r_abs3[k] <= r_abs2[k];
            end
            r_neg2 <= r_neg1;
            r_sum3 <= r_sq2[0] + r_sq2[1] + r_sq2[2];
            r_neg3 <= r_neg2;
            r_len4 <= sq_len;
            r_deg4 <= !(sq_len > r_min_mag);
            {r_abs4[2], r_abs4[1], r_abs4[0], r_neg4} <= sq_side;
        end
    end

    vn_sqrt #(.CW(CW), .SW(SQ_SIDE)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_in),
        .i_sum   (r_sum3),
        .i_side  ({r_abs3[2], r_abs3[1], r_abs3[0], r_neg3}),
        .o_valid (sq_vld),
        .o_len   (sq_len),
        .o_side  (sq_side)
    );

    t_pipe_ctl ctl_div;
    assign ctl_div = '{en: en, valid: r_vld4};

    // Lane 0 also carries the degenerate flag and the magnitude forward.
    vn_div #(.CW(CW), .FRAC_OUT(FRAC_OUT), .SW(CW + 2)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_div),
        .i_num   (r_abs4[0]),
        .i_den   (r_len4),
        .i_side  ({r_len4, r_deg4, r_neg4[0]}),
        .o_valid (dv_vld),
        .o_quot  (dv_quot[0]),
        .o_side  ({dv_len, dv_side0})
    );

    vn_div #(.CW(CW), .FRAC_OUT(FRAC_OUT), .SW(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_div),
        .i_num   (r_abs4[1]),
        .i_den   (r_len4),
        .i_side  (r_neg4[1]),
        .o_valid (),
        .o_quot  (dv_quot[1]),
        .o_side  (dv_side1)
    );

    vn_div #(.CW(CW), .FRAC_OUT(FRAC_OUT), .SW(1)) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_div),
        .i_num   (r_abs4[2]),
        .i_den   (r_len4),
        .i_side  (r_neg4[2]),
        .o_valid (),
        .o_quot  (dv_quot[2]),
        .o_side  (dv_side2)
    );

    always_comb begin
        logic [2:0] neg;
        neg = {dv_side2, dv_side1, dv_side0[0]};
        for (int k = 0; k < 3; k++) begin
            if (dv_side0[1]) begin
                n_unit[k] = '0;
            end else if (neg[k]) begin
                n_unit[k] = UW'(-{1'b0, dv_quot[k]});
            end else begin
                n_unit[k] = UW'(dv_quot[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_unit[k] <= n_unit[k];
            end
            r_len_out <= dv_len;
            r_deg_out <= dv_side0[1];
        end
    end

    assign o_valid      = r_out_vld;
    assign o_unit_x     = r_unit[0];
    assign o_unit_y     = r_unit[1];
    assign o_unit_z     = r_unit[2];
    assign o_length     = r_len_out;
    assign o_degenerate = r_deg_out;

    `include "assert_macros.svh"

    `ASSERT_CLK(a_deg_zero, i_clk, i_rst_n, (o_valid && o_degenerate) |-> (o_unit_x == 0 && o_unit_y == 0 && o_unit_z == 0), "degenerate result is not the zero vector")
    `ASSERT_CLK(a_unit_range, i_clk, i_rst_n, o_valid |-> ($signed(o_unit_x) <= $signed(UW'(1) << FRAC_OUT) && $signed(o_unit_x) >= -$signed(UW'(1) << FRAC_OUT)), "unit x out of range")
    `ASSERT_ALWAYS(a_stall_cause, i_clk, o_stall |-> (o_valid && i_stall), "input stalled without a held result")

endmodule
